// ----- design/mbb_pkg.sv -----
// ----------------------------------------------------------------------------
// mbb_pkg - shared types and constants of the meter buzzer beep controller
// Register indexes, drive kinds, field widths and the divider status bundle.
// ----------------------------------------------------------------------------
package mbb_pkg;

    localparam int MS_W     = 16;           // timers, holds, phase, periods
    localparam int ELAP_W   = 8;            // elapsed milliseconds per step
    localparam int VOL_W    = 7;            // volume percent
    localparam int KIND_W   = 2;            // drive kind
    localparam int IDX_W    = 3;            // config register index
    localparam int DVD_W    = MS_W + 1;     // phase plus elapsed, unwrapped

    typedef logic [MS_W-1:0]   ms_t;
    typedef logic [ELAP_W-1:0] elap_t;
    typedef logic [VOL_W-1:0]  vol_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DVD_W-1:0]  dvd_t;

    // configuration register indexes
    localparam idx_t REG_DIODE_HOLD  = 3'd0;
    localparam idx_t REG_LIVE_HOLD   = 3'd1;
    localparam idx_t REG_LIVE_PERIOD = 3'd2;
    localparam idx_t REG_LIVE_ON     = 3'd3;
    localparam idx_t REG_LIVE_VOLUME = 3'd4;

    // configuration reset values
    localparam ms_t  DIODE_HOLD_RST  = 16'd30;
    localparam ms_t  LIVE_HOLD_RST   = 16'd450;
    localparam ms_t  LIVE_PERIOD_RST = 16'd180;
    localparam ms_t  LIVE_ON_RST     = 16'd45;
    localparam vol_t LIVE_VOL_RST    = 7'd70;
    localparam vol_t VOL_MAX         = 7'd100;

    // drive kinds
    localparam kind_t DRIVE_NORMAL  = 2'd0;
    localparam kind_t DRIVE_FULL    = 2'd1;
    localparam kind_t DRIVE_PERCENT = 2'd2;

    // status of the shared remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/mbb_mod_unit.sv -----
// ----------------------------------------------------------------------------
// mbb_mod_unit - iterative remainder unit
// Restoring shift/subtract, one dividend bit per cycle, remainder on done.
// ----------------------------------------------------------------------------
module mbb_mod_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mbb_pkg::dvd_t      dividend,
    input  mbb_pkg::ms_t       divisor,
    output mbb_pkg::div_stat_t stat,
    output mbb_pkg::ms_t       remainder
);

    localparam int STEPS = mbb_pkg::DVD_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    mbb_pkg::dvd_t      dvd_reg;
    mbb_pkg::ms_t       rem_reg;
    mbb_pkg::ms_t       div_reg;

    mbb_pkg::dvd_t      rem_shift;
    mbb_pkg::dvd_t      rem_diff;
    mbb_pkg::ms_t       rem_next;

    // remainder stays below the divisor, so the shifted value is below twice it
    assign rem_shift = {rem_reg, dvd_reg[mbb_pkg::DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_next  = (rem_shift >= {1'b0, div_reg}) ? rem_diff[mbb_pkg::MS_W-1:0]
                                                      : rem_shift[mbb_pkg::MS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[mbb_pkg::DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/meter_buzzer_beep_controller_unit.sv -----
// ----------------------------------------------------------------------------
// meter_buzzer_beep_controller_unit - multimeter buzzer controller
// One time step per input transfer, one buzzer status transfer per step.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* carries one time step: elapsed ms, mode flags, detector hits and an
//    optional key beep length (s_tuser = load_beep marks the length valid).
//  - m_* returns one status per step: buzzer, volume, irq arm/full flag,
//    live-wire detected in m_tdata, drive kind in m_tuser.
//  - cfg_* writes the hold, period, on time and volume registers; always
//    ready, write only while no step is in flight.
// Sequencing:
//  - A step passes the evaluation state, then the final state, which loads
//    the result into the output register once the output slot is free.
//  - In live mode with the hold running and a nonzero period the phase is
//    reduced by the shared remainder unit, one bit per cycle, in a division
//    state between the evaluation and final states.
//  - s_tready is high only while the sequencer is idle, so the next step is
//    taken only after the previous result is loaded; no new step is taken
//    while one is in flight.
// Reset clears timers, phase, full latch and output valid; loads default config.
// A stalled receiver holds the result in the output register; a new step is
// still taken, and its result waits in the final state until the slot frees.
// ----------------------------------------------------------------------------
module meter_buzzer_beep_controller_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    // step input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] elapsed ms, [8] diode enable, [9] live enable, [10] continuity_hit,
    // [11] live_wire_hit, [27:12] beep_length_ms, [31:28] zero
    input  logic [31:0]          s_tdata,
    // [0] load_beep
    input  logic                 s_tuser,
    // status output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] buzzer, [7:1] volume_percent, [8] irq_arm, [9] irq_force_full,
    // [10] live_wire_detected, [15:11] zero
    output logic [15:0]          m_tdata,
    // [1:0] drive_kind
    output logic [1:0]           m_tuser,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  mbb_pkg::idx_t        cfg_index,
    input  mbb_pkg::ms_t         cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]          state_reg, state_next;

    // configuration
    mbb_pkg::ms_t        diode_hold_reg, live_hold_reg, live_period_reg, live_on_reg;
    mbb_pkg::vol_t       live_vol_reg;

    // timers
    mbb_pkg::ms_t        key_reg, dhold_reg, lhold_reg, phase_reg;
    logic                latch_reg;

    // captured step
    mbb_pkg::elap_t      elap_reg;
    logic                diode_reg, live_reg, chit_reg, lhit_reg;
    logic                key_buzz_reg;

    // output slot
    logic                m_valid_reg;
    logic [15:0]         m_data_reg;
    mbb_pkg::kind_t      m_kind_reg;

    // shared remainder unit
    logic                div_start;
    mbb_pkg::dvd_t       div_dividend;
    mbb_pkg::div_stat_t  div_stat;
    mbb_pkg::ms_t        div_rem;

    // evaluation terms
    mbb_pkg::ms_t        elap_ext;
    mbb_pkg::ms_t        dhold_down, lhold_down, lhold_new, phase_base;
    logic                out_free;
    logic                fin_buzz;
    mbb_pkg::kind_t      fin_kind;
    mbb_pkg::vol_t       fin_vol;

    assign elap_ext   = {{(mbb_pkg::MS_W-mbb_pkg::ELAP_W){1'b0}}, elap_reg};
    assign dhold_down = (dhold_reg > elap_ext) ? dhold_reg - elap_ext : '0;
    assign lhold_down = (lhold_reg > elap_ext) ? lhold_reg - elap_ext : '0;
    assign lhold_new  = lhit_reg ? live_hold_reg : lhold_down;
    // a fresh hold restarts the phase
    assign phase_base = (lhit_reg && (lhold_reg == '0)) ? '0 : phase_reg;

    assign div_dividend = {1'b0, phase_base} + {{(mbb_pkg::DVD_W-mbb_pkg::ELAP_W){1'b0}}, elap_reg};
    assign div_start    = (state_reg == ST_EVAL) && !diode_reg && live_reg
                          && !((key_reg != '0) && !diode_reg && !live_reg)
                          && (lhold_new != '0) && (live_period_reg != '0);

    assign out_free = !m_valid_reg || m_tready;

    mbb_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (live_period_reg),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EVAL;
            ST_EVAL: state_next = div_start ? ST_DIV : ST_FIN;
            ST_DIV:  if (div_stat.done) state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // result fields
    always_comb
    begin
        fin_kind = mbb_pkg::DRIVE_NORMAL;
        fin_vol  = '0;
        if (diode_reg)
        begin
            fin_buzz = (dhold_reg != '0);
            fin_kind = mbb_pkg::DRIVE_FULL;
        end
        else if (live_reg)
        begin
            fin_buzz = (lhold_reg != '0) && (phase_reg < live_on_reg);
            if (live_vol_reg != '0)
            begin
                fin_kind = mbb_pkg::DRIVE_PERCENT;
                fin_vol  = (live_vol_reg > mbb_pkg::VOL_MAX) ? mbb_pkg::VOL_MAX : live_vol_reg;
            end
        end
        else
        begin
            fin_buzz = key_buzz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            diode_hold_reg  <= mbb_pkg::DIODE_HOLD_RST;
            live_hold_reg   <= mbb_pkg::LIVE_HOLD_RST;
            live_period_reg <= mbb_pkg::LIVE_PERIOD_RST;
            live_on_reg     <= mbb_pkg::LIVE_ON_RST;
            live_vol_reg    <= mbb_pkg::LIVE_VOL_RST;
            key_reg         <= '0;
            dhold_reg       <= '0;
            lhold_reg       <= '0;
            phase_reg       <= '0;
            latch_reg       <= 1'b0;
            key_buzz_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    mbb_pkg::REG_DIODE_HOLD:  diode_hold_reg  <= cfg_data;
                    mbb_pkg::REG_LIVE_HOLD:   live_hold_reg   <= cfg_data;
                    mbb_pkg::REG_LIVE_PERIOD: live_period_reg <= cfg_data;
                    mbb_pkg::REG_LIVE_ON:     live_on_reg     <= cfg_data;
                    mbb_pkg::REG_LIVE_VOLUME: live_vol_reg    <= cfg_data[mbb_pkg::VOL_W-1:0];
                    default: ;
                endcase
            end

            // output slot: load from the final state, clear on transfer
            if ((state_reg == ST_FIN) && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tuser)
                        key_reg <= s_tdata[27:12];
                end
                ST_EVAL:
                begin
                    key_buzz_reg <= 1'b0;
                    if ((key_reg != '0) && !diode_reg && !live_reg)
                    begin
                        // key beep countdown, other timers untouched
                        if (elap_ext >= key_reg)
                            key_reg <= '0;
                        else
                        begin
                            key_reg      <= key_reg - elap_ext;
                            key_buzz_reg <= 1'b1;
                        end
                    end
                    else if (diode_reg)
                    begin
                        key_reg   <= '0;
                        latch_reg <= 1'b1;
                        dhold_reg <= chit_reg ? diode_hold_reg : dhold_down;
                        lhold_reg <= '0;
                        phase_reg <= '0;
                    end
                    else if (live_reg)
                    begin
                        key_reg   <= '0;
                        latch_reg <= 1'b0;
                        dhold_reg <= '0;
                        lhold_reg <= lhold_new;
                        // zero period or expired hold parks the phase at zero;
                        // otherwise the remainder unit writes it
                        if (!div_start)
                            phase_reg <= '0;
                    end
                    else
                    begin
                        dhold_reg <= '0;
                        lhold_reg <= '0;
                        phase_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                        phase_reg <= div_rem;
                end
                default: ;
            endcase
        end
    end

    // captured step and result payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && s_tvalid)
        begin
            elap_reg  <= s_tdata[7:0];
            diode_reg <= s_tdata[8];
            live_reg  <= s_tdata[9];
            chit_reg  <= s_tdata[10];
            lhit_reg  <= s_tdata[11];
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            m_data_reg <= {5'b0,
                           live_reg && (lhold_reg != '0),
                           latch_reg,
                           diode_reg,
                           fin_vol,
                           fin_buzz};
            m_kind_reg <= fin_kind;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_kind_reg;

endmodule

// ----- design/mbb_checker.sv -----
// ----------------------------------------------------------------------------
// mbb_checker - port-level checks of the buzzer controller
// Watches handshakes and result coding on the top-level ports.
// ----------------------------------------------------------------------------
module mbb_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [15:0]          m_tdata,
    input  logic [1:0]           m_tuser
);

    // one step at a time: an input transfer closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a step is in flight");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // a volume is reported only with percent drive, never above full scale
    a_vol_coding: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[7:1] == 7'd0) ||
                      ((m_tuser == mbb_pkg::DRIVE_PERCENT) && (m_tdata[7:1] <= 7'd100))))
        else $error("volume without percent drive");

    // diode mode arms the irq, sets the full latch and uses full drive
    a_arm_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[9] && (m_tuser == mbb_pkg::DRIVE_FULL)))
        else $error("irq armed without full drive");

endmodule

bind meter_buzzer_beep_controller_unit mbb_checker u_mbb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
